[hdl/chinese_number_speech_sequencer_macros.svh]
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms, compiled out for synthesis.
// ============================================================================
`ifndef CHINESE_NUMBER_SPEECH_SEQUENCER_MACROS_SVH
`define CHINESE_NUMBER_SPEECH_SEQUENCER_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(name, cond, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("assertion failed");

`define ASSERT_NEXT(name, cond, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed");

`define ASSERT_NEVER(name, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLIES(name, cond, expr)

`define ASSERT_NEXT(name, cond, expr)

`define ASSERT_NEVER(name, cond)

`endif

`endif

[hdl/cnss_pkg.sv]
// ============================================================================
// Number speech package
// Widths, word codes, queue entry layout and digit helpers.
// ============================================================================
`timescale 1ns / 1ps

package cnss_pkg;

    localparam int VALUE_W    = 24;
    localparam int KIND_W     = 3;
    localparam int DIGIT_W    = 4;
    localparam int NUM_SLOTS  = 8;
    localparam int SLOT_IDX_W = $clog2(NUM_SLOTS);
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [VALUE_W-1:0] VALUE_LIMIT = 24'd5000000;
    localparam logic [24:0]        MUL_DIV100  = 25'd21474837;
    localparam logic [16:0]        MUL_IP100   = 17'd83887;

    localparam logic [KIND_W-1:0] KIND_DIGIT        = 3'd0;
    localparam logic [KIND_W-1:0] KIND_TENS         = 3'd1;
    localparam logic [KIND_W-1:0] KIND_HUNDREDS     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_THOUSANDS    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TENTHOUSANDS = 3'd4;
    localparam logic [KIND_W-1:0] KIND_POINT        = 3'd5;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [DIGIT_W-1:0] digit;
    } slot_t;

    typedef struct packed {
        logic [NUM_SLOTS-1:0]  mask;
        slot_t [NUM_SLOTS-1:0] slot;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    // Splits a value below one hundred into its tens and ones digits.
    function automatic logic [2*DIGIT_W-1:0] split_dec(input logic [6:0] x);
        logic [DIGIT_W-1:0] tens;
        logic [6:0]         ones;
        tens = '0;
        for (int k = 1; k < 10; k++)
        begin
            if (x >= 7'(10 * k))
            begin
                tens = DIGIT_W'(k);
            end
        end
        ones = 7'(x - 7'(tens) * 7'd10);
        return {tens, ones[DIGIT_W-1:0]};
    endfunction

endpackage

[hdl/cnss_front.sv]
// ============================================================================
// Number speech front end
// Splits each value into decimal digits and classifies the words to speak.
// ============================================================================
`timescale 1ns / 1ps

module cnss_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [cnss_pkg::VALUE_W-1:0] value,
    input  cnss_pkg::fifo_stat_t   fifo_stat,
    output logic                   push,
    output cnss_pkg::entry_t       push_entry
);
    import cnss_pkg::*;

    logic          adv;
    logic          s1_vld_reg, s1_vld_next;
    logic          s1_ok_reg;
    logic [23:0]   s1_val_reg;
    logic [48:0]   s1_prod_reg;
    logic          s2_vld_reg, s2_vld_next;
    logic          s2_ok_reg;
    logic [15:0]   s2_ip_reg;
    logic [6:0]    s2_fp_reg;
    logic [32:0]   s2_prod_reg;
    logic [15:0]   ip;
    entry_t        ent;

    assign adv      = !fifo_stat.full;
    assign in_stall = !adv;
    assign ip       = s1_prod_reg[46:31];

    always_comb
    begin
        s1_vld_next = s1_vld_reg;
        s2_vld_next = s2_vld_reg;
        if (adv)
        begin
            s1_vld_next = in_valid;
            s2_vld_next = s1_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= s1_vld_next;
            s2_vld_reg <= s2_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_val_reg  <= value;
            s1_ok_reg   <= value < VALUE_LIMIT;
            s1_prod_reg <= 49'(value) * 49'(MUL_DIV100);
            s2_ok_reg   <= s1_ok_reg;
            s2_ip_reg   <= ip;
            s2_fp_reg   <= 7'(s1_val_reg - 24'(ip) * 24'd100);
            s2_prod_reg <= 33'(ip) * 33'(MUL_IP100);
        end
    end

    always_comb
    begin
        logic [8:0]         hi;
        logic [6:0]         lo;
        logic [6:0]         rem;
        logic [2:0]         dw;
        logic [DIGIT_W-1:0] dq, db, ds, dg, f1, f2;
        logic               bridge;
        hi = s2_prod_reg[31:23];
        lo = 7'(s2_ip_reg - 16'(hi) * 16'd100);
        if (hi >= 9'd400)
        begin
            dw = 3'd4;
        end
        else if (hi >= 9'd300)
        begin
            dw = 3'd3;
        end
        else if (hi >= 9'd200)
        begin
            dw = 3'd2;
        end
        else if (hi >= 9'd100)
        begin
            dw = 3'd1;
        end
        else
        begin
            dw = 3'd0;
        end
        rem = 7'(hi - 9'(dw) * 9'd100);
        {dq, db} = split_dec(rem);
        {ds, dg} = split_dec(lo);
        {f1, f2} = split_dec(s2_fp_reg);

        ent    = '0;
        bridge = 1'b0;
        if (dw != '0)
        begin
            ent.mask[0] = 1'b1;
            ent.slot[0] = '{kind: KIND_TENTHOUSANDS, digit: DIGIT_W'(dw)};
            bridge      = 1'b1;
        end
        if (dq != '0)
        begin
            ent.mask[1] = 1'b1;
            ent.slot[1] = '{kind: KIND_THOUSANDS, digit: dq};
            bridge      = 1'b1;
        end
        else if (bridge && (db | ds | dg) != '0)
        begin
            ent.mask[1] = 1'b1;
            ent.slot[1] = '{kind: KIND_DIGIT, digit: '0};
            bridge      = 1'b0;
        end
        if (db != '0)
        begin
            ent.mask[2] = 1'b1;
            ent.slot[2] = '{kind: KIND_HUNDREDS, digit: db};
            bridge      = 1'b1;
        end
        else if (bridge && (ds | dg) != '0)
        begin
            ent.mask[2] = 1'b1;
            ent.slot[2] = '{kind: KIND_DIGIT, digit: '0};
            bridge      = 1'b0;
        end
        if (ds != '0)
        begin
            ent.mask[3] = 1'b1;
            ent.slot[3] = '{kind: KIND_TENS, digit: ds};
        end
        else if (bridge && dg != '0)
        begin
            ent.mask[3] = 1'b1;
            ent.slot[3] = '{kind: KIND_DIGIT, digit: '0};
        end
        if (dg != '0)
        begin
            ent.mask[4] = 1'b1;
            ent.slot[4] = '{kind: KIND_DIGIT, digit: dg};
        end
        if (s2_fp_reg != '0)
        begin
            ent.mask[5] = 1'b1;
            ent.slot[5] = '{kind: KIND_POINT, digit: '0};
            ent.mask[6] = 1'b1;
            ent.slot[6] = '{kind: KIND_DIGIT, digit: f1};
            if (f2 != '0)
            begin
                ent.mask[7] = 1'b1;
                ent.slot[7] = '{kind: KIND_DIGIT, digit: f2};
            end
        end
        if (!s2_ok_reg)
        begin
            ent.mask = '0;
        end
    end

    assign push       = adv && s2_vld_reg && (ent.mask != '0);
    assign push_entry = ent;

endmodule

[hdl/cnss_fifo.sv]
// ============================================================================
// Number speech word queue
// Short queue of classified values between the front and back ends.
// ============================================================================
`timescale 1ns / 1ps
`include "chinese_number_speech_sequencer_macros.svh"

module cnss_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  cnss_pkg::entry_t     push_entry,
    input  logic                 pop,
    output cnss_pkg::entry_t     head_entry,
    output cnss_pkg::fifo_stat_t stat
);
    import cnss_pkg::*;

    entry_t                mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] cnt_reg, cnt_next;

    assign stat.full  = cnt_reg == FIFO_CNT_W'(FIFO_DEPTH);
    assign stat.empty = cnt_reg == '0;
    assign head_entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = FIFO_PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (pop)
        begin
            rd_ptr_next = FIFO_PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (push && !pop)
        begin
            cnt_next = FIFO_CNT_W'(cnt_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            cnt_next = FIFO_CNT_W'(cnt_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `ASSERT_NEVER(a_push_full, push && stat.full)
    `ASSERT_NEVER(a_pop_empty, pop && stat.empty)
    `ASSERT_NEXT(a_push_fills, push && !pop, cnt_reg != '0)

endmodule

[hdl/cnss_back.sv]
// ============================================================================
// Number speech back end
// Walks the word slots of each queued value and emits one word per beat.
// ============================================================================
`timescale 1ns / 1ps
`include "chinese_number_speech_sequencer_macros.svh"

module cnss_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cnss_pkg::fifo_stat_t          fifo_stat,
    input  cnss_pkg::entry_t              head_entry,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [cnss_pkg::KIND_W-1:0]   word_kind,
    output logic [cnss_pkg::DIGIT_W-1:0]  digit,
    output logic                          last
);
    import cnss_pkg::*;

    logic [NUM_SLOTS-1:0]  cur_mask_reg, cur_mask_next;
    slot_t [NUM_SLOTS-1:0] cur_slot_reg;
    logic                  out_vld_reg, out_vld_next;
    logic [KIND_W-1:0]     word_kind_reg;
    logic [DIGIT_W-1:0]    digit_reg;
    logic                  last_reg;
    logic                  busy;
    logic                  emit;
    logic                  finish;
    logic [SLOT_IDX_W-1:0] idx;
    logic [NUM_SLOTS-1:0]  rest;

    assign busy = cur_mask_reg != '0;
    assign emit = busy && (!out_vld_reg || !out_stall);

    always_comb
    begin
        idx = '0;
        for (int k = NUM_SLOTS - 1; k >= 0; k--)
        begin
            if (cur_mask_reg[k])
            begin
                idx = SLOT_IDX_W'(k);
            end
        end
        rest      = cur_mask_reg;
        rest[idx] = 1'b0;
    end

    assign finish = emit && (rest == '0);
    assign pop    = !fifo_stat.empty && (!busy || finish);

    always_comb
    begin
        cur_mask_next = cur_mask_reg;
        out_vld_next  = out_vld_reg;
        if (emit)
        begin
            cur_mask_next = rest;
        end
        if (pop)
        begin
            cur_mask_next = head_entry.mask;
        end
        if (emit)
        begin
            out_vld_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_mask_reg <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            cur_mask_reg <= cur_mask_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_slot_reg <= head_entry.slot;
        end
        if (emit)
        begin
            word_kind_reg <= cur_slot_reg[idx].kind;
            digit_reg     <= cur_slot_reg[idx].digit;
            last_reg      <= rest == '0;
        end
    end

    assign out_valid = out_vld_reg;
    assign word_kind = word_kind_reg;
    assign digit     = digit_reg;
    assign last      = last_reg;

    `ASSERT_NEXT(a_pop_loads, pop, cur_mask_reg != '0)
    `ASSERT_IMPLIES(a_pop_when_free, pop, !busy || finish)
    `ASSERT_IMPLIES(a_point_digit, out_vld_reg && word_kind_reg == KIND_POINT, digit_reg == '0)

endmodule

[hdl/chinese_number_speech_sequencer.sv]
// ============================================================================
// Chinese number speech sequencer
// Turns an amount in hundredths into the ordered words that read it aloud.
// ============================================================================
// Each accepted value beat yields one to eight word beats, the last one
// flagged by last; values of zero and values of 5000000 or more yield no words.
// The front end splits a value into decimal digits and classifies its words
// through its s1 and s2 registers; the value then passes the queue and the
// back end's slot register before its first word reaches the output register,
// and the rest follow one per cycle while out_stall is low. Values are accepted
// every cycle while the four-entry queue between the two ends has room, so the
// output register delivers one word per cycle sustained while out_stall is
// low; the input stalls while the queue is full.
`timescale 1ns / 1ps

module chinese_number_speech_sequencer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [cnss_pkg::VALUE_W-1:0]  value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [cnss_pkg::KIND_W-1:0]   word_kind,
    output logic [cnss_pkg::DIGIT_W-1:0]  digit,
    output logic                          last
);
    import cnss_pkg::*;

    fifo_stat_t fifo_stat;
    logic       push;
    logic       pop;
    entry_t     push_entry;
    entry_t     head_entry;

    cnss_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value      (value),
        .fifo_stat  (fifo_stat),
        .push       (push),
        .push_entry (push_entry)
    );

    cnss_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .stat       (fifo_stat)
    );

    cnss_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_stat  (fifo_stat),
        .head_entry (head_entry),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .word_kind  (word_kind),
        .digit      (digit),
        .last       (last)
    );

endmodule
